FILE: hw/rtl/sts_pkg.sv
// Shared types and constants of the sparse ternary secret sampler.
`default_nettype none
package sts_pkg;

	localparam int MAX_WEIGHT    = 256;
	localparam int MAX_RING_SIZE = 65536;
	localparam int TBL_AW        = $clog2(MAX_WEIGHT);
	localparam int RING_W        = 17;
	localparam int WEIGHT_W      = 9;
	localparam int POS_W         = 16;
	localparam int WORD_W        = 64;
	localparam int PROD_W        = TBL_AW + RING_W;
	localparam int CNT_W         = 7;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_CONFIG = 2'd1;
	localparam logic [1:0] ST_INFEASIBLE = 2'd2;
	localparam logic [1:0] ST_PLACE_FAIL = 2'd3;

	localparam logic [1:0] REG_RING   = 2'd0;
	localparam logic [1:0] REG_WEIGHT = 2'd1;
	localparam logic [1:0] REG_WINDOW = 2'd2;

	typedef struct packed {
		logic [RING_W-1:0]   ring_size;
		logic [WEIGHT_W-1:0] weight;
		logic [RING_W-1:0]   win_width;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_BK_FIRST_START,
		OP_BK_FIRST_WRITE,
		OP_BK_NEXT_START,
		OP_BK_WRITE,
		OP_SET_READY,
		OP_PL_START,
		OP_PL_MOD,
		OP_PL_FINISH,
		OP_ERR,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] err_code;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic cfg_ok;
		logic table_ready;
		logic k_zero;
		logic next_zero;
		logic lim_fail;
		logic rank_bad;
		logic order_fail;
		logic out_free;
	} stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_BK_FIRST_WAIT,
		S_BK_STEP,
		S_BK_WAIT,
		S_PL_START,
		S_PL_WS_WAIT,
		S_PL_MOD_WAIT,
		S_EMIT
	} state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sts_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module sts_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [sts_pkg::WORD_W-1:0]  dividend,
	input  wire logic [sts_pkg::CNT_W-1:0]   nbits,
	input  wire logic [sts_pkg::RING_W-1:0]  divisor,
	output logic                             done,
	output logic [sts_pkg::RING_W-1:0]       quot,
	output logic [sts_pkg::RING_W-1:0]       rem
);
	import sts_pkg::*;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] d_q;
	logic [RING_W-1:0] div_q;
	logic [RING_W-1:0] rem_q;
	logic [RING_W-1:0] quot_q;
	logic [RING_W:0]   trial;
	logic              ge;

	assign trial = {rem_q, d_q[WORD_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= nbits;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q    <= dividend;
			div_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			d_q    <= {d_q[WORD_W-2:0], 1'b0};
			rem_q  <= ge ? RING_W'(trial - {1'b0, div_q}) : trial[RING_W-1:0];
			quot_q <= {quot_q[RING_W-2:0], ge};
		end
	end

	assign done = busy_q && cnt_q == '0;
	assign quot = quot_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

FILE: hw/rtl/sts_ctrl.sv
// Sequencer for the backward pass, placement and result hand-off.
`default_nettype none
module sts_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire sts_pkg::stat_t stat,
	output sts_pkg::cmd_t       cmd
);
	import sts_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_CHECK;
			S_CHECK: begin
				if (stat.table_ready) state_d = S_PL_START;
				else if (!stat.cfg_ok) state_d = S_EMIT;
				else state_d = S_BK_FIRST_WAIT;
			end
			S_BK_FIRST_WAIT: if (stat.div_done) state_d = S_BK_STEP;
			S_BK_STEP: begin
				if (stat.k_zero) state_d = S_PL_START;
				else if (stat.next_zero) state_d = S_EMIT;
				else state_d = S_BK_WAIT;
			end
			S_BK_WAIT: begin
				if (stat.div_done) state_d = stat.lim_fail ? S_EMIT : S_BK_STEP;
			end
			S_PL_START: state_d = stat.rank_bad ? S_EMIT : S_PL_WS_WAIT;
			S_PL_WS_WAIT: begin
				if (stat.div_done) state_d = stat.order_fail ? S_EMIT : S_PL_MOD_WAIT;
			end
			S_PL_MOD_WAIT: if (stat.div_done) state_d = S_EMIT;
			S_EMIT: if (stat.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op       = OP_NONE;
		cmd.err_code = ST_OK;
		in_stall     = state_q != S_IDLE;
		case (state_q)
			S_IDLE: if (in_valid) cmd.op = OP_LATCH;
			S_CHECK: begin
				if (!stat.table_ready) begin
					if (!stat.cfg_ok) begin
						cmd.op       = OP_ERR;
						cmd.err_code = ST_BAD_CONFIG;
					end else begin
						cmd.op = OP_BK_FIRST_START;
					end
				end
			end
			S_BK_FIRST_WAIT: if (stat.div_done) cmd.op = OP_BK_FIRST_WRITE;
			S_BK_STEP: begin
				if (stat.k_zero) begin
					cmd.op = OP_SET_READY;
				end else if (stat.next_zero) begin
					cmd.op       = OP_ERR;
					cmd.err_code = ST_INFEASIBLE;
				end else begin
					cmd.op = OP_BK_NEXT_START;
				end
			end
			S_BK_WAIT: begin
				if (stat.div_done) begin
					if (stat.lim_fail) begin
						cmd.op       = OP_ERR;
						cmd.err_code = ST_INFEASIBLE;
					end else begin
						cmd.op = OP_BK_WRITE;
					end
				end
			end
			S_PL_START: begin
				if (stat.rank_bad) begin
					cmd.op       = OP_ERR;
					cmd.err_code = ST_PLACE_FAIL;
				end else begin
					cmd.op = OP_PL_START;
				end
			end
			S_PL_WS_WAIT: begin
				if (stat.div_done) begin
					if (stat.order_fail) begin
						cmd.op       = OP_ERR;
						cmd.err_code = ST_PLACE_FAIL;
					end else begin
						cmd.op = OP_PL_MOD;
					end
				end
			end
			S_PL_MOD_WAIT: if (stat.div_done) cmd.op = OP_PL_FINISH;
			S_EMIT: if (stat.out_free) cmd.op = OP_EMIT;
			default: cmd.op = OP_NONE;
		endcase
	end
endmodule
`default_nettype wire

FILE: hw/rtl/sts_datapath.sv
// Run state, latest-position table, window arithmetic and output register.
`default_nettype none
module sts_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sts_pkg::cfg_t                 cfg,
	input  wire logic                          cfg_we,
	input  wire sts_pkg::cmd_t                 cmd,
	output sts_pkg::stat_t                     stat,
	input  wire logic [sts_pkg::WORD_W-1:0]    offset_random,
	input  wire logic                          sign_random,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [sts_pkg::POS_W-1:0]          position,
	output logic signed [1:0]                  value,
	output logic                               last,
	output logic [1:0]                         status
);
	import sts_pkg::*;

	logic [WEIGHT_W-1:0] rank_q;
	logic [RING_W-1:0]   minpos_q;
	logic                ready_q;
	logic [TBL_AW-1:0]   k_q;
	logic [POS_W-1:0]    next_q;
	logic [POS_W-1:0]    rd_q;
	logic [RING_W-1:0]   start_q;
	logic [WORD_W-1:0]   offset_q;
	logic                sign_q;
	logic [POS_W-1:0]    mem [MAX_WEIGHT];

	logic [POS_W-1:0]    res_pos_q;
	logic [1:0]          res_val_q;
	logic                res_last_q;
	logic [1:0]          res_st_q;
	logic                out_valid_q;
	logic [POS_W-1:0]    out_pos_q;
	logic [1:0]          out_val_q;
	logic                out_last_q;
	logic [1:0]          out_st_q;

	logic [TBL_AW-1:0]   k_sel;
	logic [PROD_W-1:0]   prod;
	logic                div_start;
	logic [WORD_W-1:0]   div_dividend;
	logic [CNT_W-1:0]    div_nbits;
	logic [RING_W-1:0]   div_divisor;
	logic                div_done;
	logic [RING_W-1:0]   quot;
	logic [RING_W-1:0]   rem;

	logic [RING_W-1:0]   half;
	logic [RING_W-1:0]   max_start;
	logic [RING_W-1:0]   ws_raw;
	logic [RING_W-1:0]   ws;
	logic [RING_W-1:0]   ws_top;
	logic [RING_W-1:0]   lim;
	logic [RING_W-1:0]   start_c;
	logic [RING_W-1:0]   span;
	logic [RING_W-1:0]   pos;
	logic [WEIGHT_W-1:0] rank_inc;
	logic                cfg_ok;
	logic                tbl_we;
	logic [TBL_AW-1:0]   tbl_wa;
	logic [POS_W-1:0]    tbl_wd;
	logic                end_run;

	always_comb begin
		case (cmd.op)
			OP_BK_FIRST_START: k_sel = TBL_AW'(cfg.weight - WEIGHT_W'(1));
			OP_BK_NEXT_START:  k_sel = k_q - TBL_AW'(1);
			default:           k_sel = rank_q[TBL_AW-1:0];
		endcase
	end

	assign prod = PROD_W'(k_sel) * PROD_W'(cfg.ring_size);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = {prod, (WORD_W - PROD_W)'(0)};
		div_nbits    = CNT_W'(PROD_W);
		div_divisor  = RING_W'(cfg.weight);
		case (cmd.op)
			OP_BK_FIRST_START, OP_BK_NEXT_START, OP_PL_START: div_start = 1'b1;
			OP_PL_MOD: begin
				div_start    = 1'b1;
				div_dividend = offset_q;
				div_nbits    = CNT_W'(WORD_W);
				div_divisor  = span;
			end
			default: div_start = 1'b0;
		endcase
	end

	sts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.nbits    (div_nbits),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	assign half      = cfg.win_width >> 1;
	assign max_start = cfg.ring_size - cfg.win_width;
	assign ws_raw    = (quot > half) ? quot - half : '0;
	assign ws        = (ws_raw > max_start) ? max_start : ws_raw;
	assign ws_top    = ws + cfg.win_width - RING_W'(1);
	assign lim       = ({1'b0, next_q} - RING_W'(1) < ws_top) ?
	                   {1'b0, next_q} - RING_W'(1) : ws_top;
	assign start_c   = (minpos_q > ws) ? minpos_q : ws;
	assign span      = {1'b0, rd_q} - start_c + RING_W'(1);
	assign pos       = start_q + rem;
	assign rank_inc  = rank_q + WEIGHT_W'(1);

	assign cfg_ok = !(cfg.ring_size == '0 || cfg.ring_size > RING_W'(MAX_RING_SIZE)
	               || cfg.weight == '0 || cfg.weight > WEIGHT_W'(MAX_WEIGHT)
	               || RING_W'(cfg.weight) > cfg.ring_size
	               || cfg.win_width == '0 || cfg.win_width > cfg.ring_size);

	always_comb begin
		tbl_we = 1'b0;
		tbl_wa = k_q;
		tbl_wd = ws_top[POS_W-1:0];
		case (cmd.op)
			OP_BK_FIRST_WRITE: tbl_we = 1'b1;
			OP_BK_WRITE: begin
				tbl_we = 1'b1;
				tbl_wd = lim[POS_W-1:0];
			end
			default: tbl_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we) mem[tbl_wa] <= tbl_wd;
		if (cmd.op == OP_PL_START) rd_q <= mem[rank_q[TBL_AW-1:0]];
	end

	assign end_run = cfg_we || cmd.op == OP_ERR
	                 || (cmd.op == OP_PL_FINISH && rank_inc == cfg.weight);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q   <= '0;
			minpos_q <= '0;
			ready_q  <= 1'b0;
		end else if (end_run) begin
			rank_q   <= '0;
			minpos_q <= '0;
			ready_q  <= 1'b0;
		end else if (cmd.op == OP_SET_READY) begin
			ready_q <= 1'b1;
		end else if (cmd.op == OP_PL_FINISH) begin
			rank_q   <= rank_inc;
			minpos_q <= pos + RING_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				offset_q <= offset_random;
				sign_q   <= sign_random;
			end
			OP_BK_FIRST_START, OP_BK_NEXT_START, OP_PL_START: k_q <= k_sel;
			OP_BK_FIRST_WRITE: next_q <= ws_top[POS_W-1:0];
			OP_BK_WRITE:       next_q <= lim[POS_W-1:0];
			OP_PL_MOD:         start_q <= start_c;
			OP_PL_FINISH: begin
				res_pos_q  <= pos[POS_W-1:0];
				res_val_q  <= sign_q ? 2'b01 : 2'b11;
				res_last_q <= rank_inc == cfg.weight;
				res_st_q   <= ST_OK;
			end
			OP_ERR: begin
				res_pos_q  <= '0;
				res_val_q  <= 2'b00;
				res_last_q <= 1'b1;
				res_st_q   <= cmd.err_code;
			end
			default: k_q <= k_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			out_pos_q  <= res_pos_q;
			out_val_q  <= res_val_q;
			out_last_q <= res_last_q;
			out_st_q   <= res_st_q;
		end
	end

	assign stat.div_done    = div_done;
	assign stat.cfg_ok      = cfg_ok;
	assign stat.table_ready = ready_q;
	assign stat.k_zero      = k_q == '0;
	assign stat.next_zero   = next_q == '0;
	assign stat.lim_fail    = lim < ws;
	assign stat.rank_bad    = rank_q >= cfg.weight;
	assign stat.order_fail  = start_c > {1'b0, rd_q};
	assign stat.out_free    = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign position  = out_pos_q;
	assign value     = out_val_q;
	assign last      = out_last_q;
	assign status    = out_st_q;
endmodule
`default_nettype wire

FILE: hw/rtl/sparse_ternary_secret_sampler_core.sv
// Top level of the sparse ternary secret sampler: register port, controller, datapath.
//
// Input channel: in_valid/in_stall carry one word of offset_random and sign_random.
// Output channel: out_valid/out_stall carry position, value, last and status.
// A word moves at a clock edge where valid is high and stall is low.
// One word in gives exactly one word out. Items are handled one at a time.
// A placement uses the shared radix-2 divider twice, with control states between: first
// for the window center k*N/h, then for offset_random modulo span. The result is put
// out before the next word is taken. The first item of a secret first runs the backward
// pass over all ranks, one division per rank on the same divider.
// Registers ring size, weight and window width sit at byte addresses 0, 4, 8;
// a write to any of them ends the current run. Write them only while the block is idle.
// Reset restores the register defaults and clears the run state.
// While out_stall holds a result, the output register keeps it; the block still takes
// the next input word and computes it, then holds that result until the held one
// has been taken.
`default_nettype none
module sparse_ternary_secret_sampler_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [3:0]                 paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [sts_pkg::WORD_W-1:0] offset_random,
	input  wire logic                       sign_random,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [sts_pkg::POS_W-1:0]       position,
	output logic signed [1:0]               value,
	output logic                            last,
	output logic [1:0]                      status
);
	import sts_pkg::*;

	cfg_t       cfg_q;
	logic       wr;
	logic       cfg_we;
	logic [1:0] idx;
	cmd_t       cmd;
	stat_t      stat;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite;
	assign cfg_we = wr && (idx == REG_RING || idx == REG_WEIGHT || idx == REG_WINDOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ring_size <= RING_W'(65536);
			cfg_q.weight    <= WEIGHT_W'(64);
			cfg_q.win_width <= RING_W'(4096);
		end else if (wr) begin
			case (idx)
				REG_RING:   cfg_q.ring_size <= pwdata[RING_W-1:0];
				REG_WEIGHT: cfg_q.weight    <= pwdata[WEIGHT_W-1:0];
				REG_WINDOW: cfg_q.win_width <= pwdata[RING_W-1:0];
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RING:   prdata = 32'(cfg_q.ring_size);
			REG_WEIGHT: prdata = 32'(cfg_q.weight);
			REG_WINDOW: prdata = 32'(cfg_q.win_width);
			default:    prdata = '0;
		endcase
	end

	sts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	sts_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cfg_we        (cfg_we),
		.cmd           (cmd),
		.stat          (stat),
		.offset_random (offset_random),
		.sign_random   (sign_random),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.position      (position),
		.value         (value),
		.last          (last),
		.status        (status)
	);
endmodule
`default_nettype wire
